FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the run allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(name, clk, rstn, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

`define ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rstn, expr, msg)
`define ASSERT_IMPLY(name, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/ffpa_pkg.sv
// Types, codes and helper functions of the first-fit page allocator.
package ffpa_pkg;

  localparam int PAGE_W = 16;
  localparam int LEN_W  = 17;
  localparam int ST_W   = 3;
  localparam int ACT_W  = 2;

  localparam int NUM_PAGES = 65536;
  localparam int CAP_I     = (NUM_PAGES < 131071) ? NUM_PAGES : 131071;
  localparam logic [LEN_W-1:0] TOTAL_CAP = LEN_W'(CAP_I);

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_EXCEED = 3'd1;
  localparam logic [ST_W-1:0] ST_NOFIT  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO   = 3'd4;

  // One free run as stored in the table.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [PAGE_W-1:0] start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Everything the sequencer needs to know about the entry just read.
  typedef struct packed {
    logic              len_ge;
    logic              len_gt;
    logic              touch_after;
    logic              touch_before;
    logic              fits_before;
    logic [PAGE_W-1:0] rem_start;
    logic [LEN_W-1:0]  rem_len;
    logic [LEN_W-1:0]  merged_len;
  } alu_res_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_len = s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    end
  endfunction

  function automatic logic [LEN_W-1:0] sat_total(input logic [LEN_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_total = (s > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : s[LEN_W-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/ffpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ffpa_alu.sv
// Shared compare and add unit applied to one table entry per cycle.
module ffpa_alu (
  input  ffpa_pkg::entry_t                  ent,
  input  logic [ffpa_pkg::PAGE_W-1:0]       bs,
  input  logic [ffpa_pkg::LEN_W-1:0]        bl,
  input  logic [ffpa_pkg::LEN_W-1:0]        n,
  output ffpa_pkg::alu_res_t                res
);

  logic [ffpa_pkg::LEN_W:0] blk_end;
  logic [ffpa_pkg::LEN_W:0] ent_end;
  logic [ffpa_pkg::LEN_W:0] ent_start_x;
  logic [ffpa_pkg::LEN_W:0] bs_x;

  // Sums are kept one bit wider so that no end address wraps.
  assign ent_start_x = {2'b00, ent.start};
  assign bs_x        = {2'b00, bs};
  assign blk_end     = bs_x + {1'b0, bl};
  assign ent_end     = ent_start_x + {1'b0, ent.len};

  always_comb begin
    res.len_ge       = (ent.len >= n);
    res.len_gt       = (ent.len > n);
    res.touch_after  = (blk_end == ent_start_x);
    res.touch_before = (ent_end == bs_x);
    res.fits_before  = (blk_end <= ent_start_x);
    res.rem_start    = ent.start + n[ffpa_pkg::PAGE_W-1:0];
    res.rem_len      = ent.len - n;
    res.merged_len   = ffpa_pkg::sat_len(bl, ent.len);
  end

endmodule

FILE: hw/rtl/first_fit_page_allocator_top.sv
// Top level of the first-fit page allocator: sequencer, run table and result register.
//
// Requests enter on the in_ stream (one transaction per request) and each one
// yields exactly one result transaction on the out_ stream. in_tready is high
// only while the sequencer is idle; a request is worked on to its end before
// the next one is taken. The result sits in an output register, so a new
// request can be accepted while the previous result still waits for out_tready.
// Work per request:
//   add, zero count, unused action, allocate beyond total: decided in the idle state.
//   allocate: a first-fit scan over the runs, plus a shift down of the table
//     when an exactly fitting run is removed.
//   free: a merge pass, then, unless the kept runs fill the table, a search for
//     the insert position and a shift up.
// The sequencer reads one entry per cycle through the run table's single read
// port, and the read data is registered.
// After the synchronous reset the table is empty and the free total is zero.
// If the receiver stalls, the finished result waits in the sequencer's
// response state until the output register is free.
module first_fit_page_allocator_top #(
  parameter int MAX_RUNS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[1:0], base_page[17:2], page_count[34:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[2:0], grant_page[18:3], free_total[35:19]
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam logic [CW-1:0] RUNS_MAX = CW'(MAX_RUNS);

  typedef enum logic [6:0] {
    S_IDLE        = 7'b0000001,
    S_ALLOC_SCAN  = 7'b0000010,
    S_ALLOC_SHIFT = 7'b0000100,
    S_FREE_MERGE  = 7'b0001000,
    S_FREE_FIND   = 7'b0010000,
    S_FREE_SHIFT  = 7'b0100000,
    S_RESP        = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]                  run_count_r, run_count_nxt;
  logic [ffpa_pkg::LEN_W-1:0]     total_r, total_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  pidx_r, pidx_nxt;
  logic                           pv_r, pv_nxt;
  logic [CW-1:0]                  k_r, k_nxt;
  logic [CW-1:0]                  j_r, j_nxt;
  logic [ffpa_pkg::PAGE_W-1:0]    bs_r, bs_nxt;
  logic [ffpa_pkg::LEN_W-1:0]     bl_r, bl_nxt;
  logic [ffpa_pkg::LEN_W-1:0]     n_r, n_nxt;
  logic [ffpa_pkg::ST_W-1:0]      status_r, status_nxt;
  logic [ffpa_pkg::PAGE_W-1:0]    page_r, page_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [39:0]                    out_data_r, out_data_nxt;

  logic [ffpa_pkg::ACT_W-1:0]     in_action;
  logic [ffpa_pkg::PAGE_W-1:0]    in_base;
  logic [ffpa_pkg::LEN_W-1:0]     in_count;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  ffpa_pkg::entry_t               ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [ffpa_pkg::ENTRY_W-1:0]   ram_rdata;
  ffpa_pkg::entry_t               rd_ent;
  ffpa_pkg::alu_res_t             alu;

  assign in_action = in_tdata[1:0];
  assign in_base   = in_tdata[17:2];
  assign in_count  = in_tdata[34:18];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign rd_ent     = ffpa_pkg::entry_t'(ram_rdata);

  ffpa_ram #(
    .WIDTH (ffpa_pkg::ENTRY_W),
    .DEPTH (MAX_RUNS)
  ) u_runs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffpa_alu u_alu (
    .ent (rd_ent),
    .bs  (bs_r),
    .bl  (bl_r),
    .n   (n_r),
    .res (alu)
  );

  always_comb begin
    state_nxt     = state_r;
    run_count_nxt = run_count_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pv_nxt        = pv_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    bs_nxt        = bs_r;
    bl_nxt        = bl_r;
    n_nxt         = n_r;
    status_nxt    = status_r;
    page_nxt      = page_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt      = in_count;
          bs_nxt     = in_base;
          bl_nxt     = in_count;
          idx_nxt    = '0;
          pv_nxt     = 1'b0;
          k_nxt      = '0;
          page_nxt   = '0;
          status_nxt = ffpa_pkg::ST_OK;
          state_nxt  = S_RESP;
          if (in_action != ffpa_pkg::ACT_RSVD && in_count == '0) begin
            status_nxt = ffpa_pkg::ST_ZERO;
          end else begin
            case (in_action)
              ffpa_pkg::ACT_ADD: begin
                if (run_count_r >= RUNS_MAX) begin
                  status_nxt = ffpa_pkg::ST_FULL;
                end else begin
                  ram_we          = 1'b1;
                  ram_waddr       = run_count_r[AW-1:0];
                  ram_wdata.start = in_base;
                  ram_wdata.len   = in_count;
                  run_count_nxt   = run_count_r + 1'b1;
                  total_nxt       = ffpa_pkg::sat_total(total_r, in_count);
                end
              end
              ffpa_pkg::ACT_ALLOC: begin
                if (in_count > total_r) begin
                  status_nxt = ffpa_pkg::ST_EXCEED;
                end else begin
                  state_nxt = S_ALLOC_SCAN;
                end
              end
              ffpa_pkg::ACT_FREE: begin
                state_nxt = S_FREE_MERGE;
              end
              default: begin
                status_nxt = ffpa_pkg::ST_OK;
              end
            endcase
          end
        end
      end

      S_ALLOC_SCAN: begin
        if (idx_r < run_count_r) begin
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + 1'b1;
          pidx_nxt  = idx_r;
          pv_nxt    = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && alu.len_ge) begin
          // First fit found; the read already in flight is dropped.
          page_nxt = rd_ent.start;
          pv_nxt   = 1'b0;
          if (alu.len_gt) begin
            ram_we          = 1'b1;
            ram_waddr       = pidx_r[AW-1:0];
            ram_wdata.start = alu.rem_start;
            ram_wdata.len   = alu.rem_len;
            total_nxt       = total_r - n_r;
            status_nxt      = ffpa_pkg::ST_OK;
            state_nxt       = S_RESP;
          end else begin
            idx_nxt   = pidx_r + 1'b1;
            state_nxt = S_ALLOC_SHIFT;
          end
        end else if (!pv_r && idx_r >= run_count_r) begin
          status_nxt = ffpa_pkg::ST_NOFIT;
          state_nxt  = S_RESP;
        end
      end

      S_ALLOC_SHIFT: begin
        if (idx_r < run_count_r) begin
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + 1'b1;
          pidx_nxt  = idx_r;
          pv_nxt    = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pidx_r - 1'b1);
          ram_wdata = rd_ent;
        end else if (idx_r >= run_count_r) begin
          run_count_nxt = run_count_r - 1'b1;
          total_nxt     = total_r - n_r;
          status_nxt    = ffpa_pkg::ST_OK;
          state_nxt     = S_RESP;
        end
      end

      S_FREE_MERGE: begin
        if (idx_r < run_count_r) begin
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + 1'b1;
          pidx_nxt  = idx_r;
          pv_nxt    = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (alu.touch_after) begin
            bl_nxt = alu.merged_len;
          end else if (alu.touch_before) begin
            bs_nxt = rd_ent.start;
            bl_nxt = alu.merged_len;
          end else begin
            // Kept runs are compacted in place; the write slot never passes the read.
            ram_we    = 1'b1;
            ram_waddr = k_r[AW-1:0];
            ram_wdata = rd_ent;
            k_nxt     = k_r + 1'b1;
          end
        end else if (idx_r >= run_count_r) begin
          if (k_r >= RUNS_MAX) begin
            status_nxt = ffpa_pkg::ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            idx_nxt   = '0;
            pv_nxt    = 1'b0;
            state_nxt = S_FREE_FIND;
          end
        end
      end

      S_FREE_FIND: begin
        if (idx_r < k_r) begin
          ram_raddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + 1'b1;
          pidx_nxt  = idx_r;
          pv_nxt    = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && alu.fits_before) begin
          j_nxt     = pidx_r;
          idx_nxt   = k_r;
          pv_nxt    = 1'b0;
          state_nxt = S_FREE_SHIFT;
        end else if (!pv_r && idx_r >= k_r) begin
          j_nxt     = k_r;
          idx_nxt   = k_r;
          pv_nxt    = 1'b0;
          state_nxt = S_FREE_SHIFT;
        end
      end

      S_FREE_SHIFT: begin
        // Walk down from the top so each entry moves up before it is overwritten.
        if (idx_r > j_r) begin
          ram_raddr = AW'(idx_r - 1'b1);
          idx_nxt   = idx_r - 1'b1;
          pidx_nxt  = idx_r - 1'b1;
          pv_nxt    = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pidx_r + 1'b1);
          ram_wdata = rd_ent;
        end else if (idx_r <= j_r) begin
          ram_we          = 1'b1;
          ram_waddr       = j_r[AW-1:0];
          ram_wdata.start = bs_r;
          ram_wdata.len   = bl_r;
          run_count_nxt   = k_r + 1'b1;
          total_nxt       = ffpa_pkg::sat_total(total_r, n_r);
          status_nxt      = ffpa_pkg::ST_OK;
          state_nxt       = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, total_r, page_r, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_count_r <= '0;
      total_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_count_r <= run_count_nxt;
      total_r     <= total_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    bs_r       <= bs_nxt;
    bl_r       <= bl_nxt;
    n_r        <= n_nxt;
    status_r   <= status_nxt;
    page_r     <= page_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, run_count_r <= RUNS_MAX, "run count above table depth")
  `ASSERT_ALWAYS(a_total_bound, clk, rst_n, total_r <= ffpa_pkg::TOTAL_CAP, "free total above cap")
  `ASSERT_IMPLY(a_compact_order, clk, rst_n, state_r == S_FREE_MERGE && ram_we, k_r <= pidx_r, "compaction write passed the read")
  `ASSERT_IMPLY(a_shift_range, clk, rst_n, state_r == S_FREE_SHIFT && pv_r, pidx_r >= j_r && pidx_r < k_r, "shift out of range")
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second request taken while busy")

endmodule

FILE: dv/tb_top.sv
// Testbench for the first-fit page allocator: streamed requests checked against a run-table predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int PAGE_W     = ffpa_pkg::PAGE_W;
  localparam int LEN_W      = ffpa_pkg::LEN_W;
  localparam int ST_W       = ffpa_pkg::ST_W;
  localparam int ACT_W      = ffpa_pkg::ACT_W;
  localparam int RUN_SLOTS  = 64;
  localparam int LEN_LIMIT  = 131071;
  localparam int ITEM_GOAL  = 1150;
  localparam int DRAIN_WAIT = 3 * RUN_SLOTS + 16;

  typedef struct packed {
    logic [LEN_W-1:0]  total;
    logic [PAGE_W-1:0] page;
    logic [ST_W-1:0]   status;
  } alloc_result_t;

  // Tracks the free-run table and the free total, and holds the results still to come.
  class alloc_scoreboard;
    logic [PAGE_W-1:0] run_start [RUN_SLOTS];
    logic [LEN_W-1:0]  run_len [RUN_SLOTS];
    int unsigned       run_cnt;
    logic [LEN_W-1:0]  free_total;
    alloc_result_t     result_q[$];
    int unsigned       errors;
    logic [ST_W-1:0]   last_status;
    logic [PAGE_W-1:0] last_page;

    function new();
      run_cnt    = 0;
      free_total = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    function void note_request(input logic [ACT_W-1:0] act, input logic [PAGE_W-1:0] base,
                               input logic [LEN_W-1:0] cnt);
      int unsigned   ks [RUN_SLOTS];
      int unsigned   kl [RUN_SLOTS];
      int unsigned   bs, bl, k, i, j, sum;
      alloc_result_t res;
      begin
        res = '0;
        if (act != ffpa_pkg::ACT_RSVD && cnt == 0) begin
          res.status = ffpa_pkg::ST_ZERO;
        end else begin
          case (act)
            ffpa_pkg::ACT_ADD: begin
              if (run_cnt >= RUN_SLOTS) begin
                res.status = ffpa_pkg::ST_FULL;
              end else begin
                run_start[run_cnt] = base;
                run_len[run_cnt]   = cnt;
                run_cnt++;
                sum = free_total + cnt;
                free_total = (sum > ffpa_pkg::TOTAL_CAP) ? ffpa_pkg::TOTAL_CAP : LEN_W'(sum);
              end
            end
            ffpa_pkg::ACT_ALLOC: begin
              if (cnt > free_total) begin
                res.status = ffpa_pkg::ST_EXCEED;
              end else begin
                for (i = 0; i < run_cnt; i++) begin
                  if (run_len[i] >= cnt) break;
                end
                if (i >= run_cnt) begin
                  res.status = ffpa_pkg::ST_NOFIT;
                end else begin
                  res.page = run_start[i];
                  if (run_len[i] > cnt) begin
                    // The remainder start wraps around the page space.
                    run_start[i] = PAGE_W'(run_start[i] + cnt);
                    run_len[i]   = run_len[i] - cnt;
                  end else begin
                    for (j = i; j + 1 < run_cnt; j++) begin
                      run_start[j] = run_start[j+1];
                      run_len[j]   = run_len[j+1];
                    end
                    run_cnt--;
                  end
                  free_total = free_total - cnt;
                end
              end
            end
            ffpa_pkg::ACT_FREE: begin
              bs = base;
              bl = cnt;
              k  = 0;
              // One merge pass in table order; the sums are not wrapped.
              for (i = 0; i < run_cnt; i++) begin
                if (bs + bl == run_start[i]) begin
                  sum = bl + run_len[i];
                  bl  = (sum > LEN_LIMIT) ? LEN_LIMIT : sum;
                end else if (run_start[i] + run_len[i] == bs) begin
                  bs  = run_start[i];
                  sum = bl + run_len[i];
                  bl  = (sum > LEN_LIMIT) ? LEN_LIMIT : sum;
                end else begin
                  ks[k] = run_start[i];
                  kl[k] = run_len[i];
                  k++;
                end
              end
              if (k >= RUN_SLOTS) begin
                res.status = ffpa_pkg::ST_FULL;
              end else begin
                for (j = 0; j < k; j++) begin
                  if (bs + bl <= ks[j]) break;
                end
                for (i = k; i > j; i--) begin
                  ks[i] = ks[i-1];
                  kl[i] = kl[i-1];
                end
                ks[j] = bs;
                kl[j] = bl;
                k++;
                for (i = 0; i < k; i++) begin
                  run_start[i] = PAGE_W'(ks[i]);
                  run_len[i]   = LEN_W'(kl[i]);
                end
                run_cnt = k;
                sum = free_total + cnt;
                free_total = (sum > ffpa_pkg::TOTAL_CAP) ? ffpa_pkg::TOTAL_CAP : LEN_W'(sum);
              end
            end
            default: res.status = ffpa_pkg::ST_OK;
          endcase
        end
        res.total   = free_total;
        last_status = res.status;
        last_page   = res.page;
        result_q.push_back(res);
      end
    endfunction

    function void check_result(input logic [39:0] tdata);
      alloc_result_t want;
      alloc_result_t got;
      begin
        got = tdata[35:0];
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result status=%0d page=%0d total=%0d",
                     got.status, got.page, got.total);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.page !== want.page ||
              got.total !== want.total) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: status %0d/%0d page %0d/%0d total %0d/%0d (expected/actual)",
                       want.status, got.status, want.page, got.page, want.total, got.total);
          end
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // action[1:0], base_page[17:2], page_count[34:18]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // status[2:0], grant_page[18:3], free_total[35:19]

  alloc_scoreboard   sb = new();
  int unsigned       items_sent;
  int unsigned       results_seen;
  logic [PAGE_W-1:0] blk_base[$];
  logic [LEN_W-1:0]  blk_len[$];

  first_fit_page_allocator_top #(
    .MAX_RUNS (RUN_SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_req(input logic [ACT_W-1:0] act, input logic [PAGE_W-1:0] base,
                          input logic [LEN_W-1:0] cnt);
    while (!(items_sent >= 500 && items_sent < 650) && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, cnt, base, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(act, base, cnt);
    items_sent++;
    if (act == ffpa_pkg::ACT_ALLOC && sb.last_status == ffpa_pkg::ST_OK &&
        blk_base.size() < 256) begin
      blk_base.push_back(sb.last_page);
      blk_len.push_back(cnt);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Removes runs from the front by allocating each one whole.
  task automatic drain_table();
    int n;
    n = 0;
    while (sb.run_cnt > 0 && sb.run_len[0] <= sb.free_total && n < RUN_SLOTS + 4) begin
      send_req(ffpa_pkg::ACT_ALLOC, PAGE_W'($urandom()), sb.run_len[0]);
      n++;
    end
  endtask

  // Receiver: random backpressure, one long hold-off, and a stretch without stalls.
  initial begin
    int hold_at;
    bit held;
    hold_at = $urandom_range(200, 600);
    held    = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        results_seen++;
      end
      if (!held && results_seen >= hold_at) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_tready <= ((results_seen >= 700 && results_seen < 850) ||
                     $urandom_range(99) >= 18);
    end
  end

  initial begin
    #(4_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned       ep, ops, idx, r;
    logic [PAGE_W-1:0] b0;
    logic [LEN_W-1:0]  len;
    items_sent   = 0;
    results_seen = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: zero counts, the unused action, splits with wrap, merges and saturation.
    send_req(ffpa_pkg::ACT_ALLOC, 16'd0, 17'd1);
    send_req(ffpa_pkg::ACT_ADD, 16'd1234, 17'd0);
    send_req(ffpa_pkg::ACT_ALLOC, 16'd0, 17'd0);
    send_req(ffpa_pkg::ACT_FREE, 16'hFFFF, 17'd0);
    send_req(ffpa_pkg::ACT_RSVD, 16'hFFFF, 17'd65536);
    send_req(ffpa_pkg::ACT_RSVD, 16'd0, 17'd0);
    send_req(ffpa_pkg::ACT_ADD, 16'd65530, 17'd20);
    send_req(ffpa_pkg::ACT_ALLOC, 16'hFFFF, 17'd10);
    send_req(ffpa_pkg::ACT_ALLOC, 16'd0, 17'd10);
    send_req(ffpa_pkg::ACT_ADD, 16'd100, 17'd50);
    send_req(ffpa_pkg::ACT_ADD, 16'd65535, 17'd1);
    send_req(ffpa_pkg::ACT_ALLOC, 16'd0, 17'd60);
    send_req(ffpa_pkg::ACT_ALLOC, 16'd0, 17'd20);
    send_req(ffpa_pkg::ACT_ADD, 16'd1000, 17'd40);
    send_req(ffpa_pkg::ACT_ALLOC, 16'd0, 17'd50);
    send_req(ffpa_pkg::ACT_FREE, 16'd100, 17'd20);
    send_req(ffpa_pkg::ACT_FREE, 16'd150, 17'd10);
    send_req(ffpa_pkg::ACT_FREE, 16'd160, 17'd840);
    send_req(ffpa_pkg::ACT_FREE, 16'd50, 17'd10);
    send_req(ffpa_pkg::ACT_FREE, 16'd0, 17'd5);
    send_req(ffpa_pkg::ACT_ADD, 16'd0, 17'd65536);
    send_req(ffpa_pkg::ACT_ALLOC, 16'd0, 17'd65536);
    send_req(ffpa_pkg::ACT_FREE, 16'd65535, 17'd65536);
    wait_idle();

    while (items_sent < ITEM_GOAL) begin
      ep = $urandom_range(99);
      if ($urandom_range(9) == 0) wait_idle();
      if (ep < 55) begin
        // Pool traffic: new regions, allocations, and frees of earlier allocations.
        repeat ($urandom_range(1, 3)) begin
          if (sb.run_cnt < RUN_SLOTS - 8) begin
            len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(1, 65536)) :
                                             LEN_W'($urandom_range(1, 4096));
            send_req(ffpa_pkg::ACT_ADD, PAGE_W'($urandom()), len);
          end
        end
        ops = $urandom_range(10, 30);
        repeat (ops) begin
          if (blk_base.size() > 0 && $urandom_range(1) == 1) begin
            idx = $urandom_range(blk_base.size() - 1);
            b0  = blk_base[idx];
            len = blk_len[idx];
            blk_base.delete(idx);
            blk_len.delete(idx);
            send_req(ffpa_pkg::ACT_FREE, b0, len);
          end else begin
            r = $urandom_range(99);
            len = (r < 70) ? LEN_W'($urandom_range(1, 256)) :
                  (r < 95) ? LEN_W'($urandom_range(1, 8192)) :
                             LEN_W'($urandom_range(1, 65536));
            send_req(ffpa_pkg::ACT_ALLOC, PAGE_W'($urandom()), len);
          end
        end
      end else if (ep < 70) begin
        // Fill the table with isolated one-page runs, then push past full on add and free.
        drain_table();
        b0 = PAGE_W'($urandom_range(0, 60000));
        for (int i = 0; i < RUN_SLOTS + 2; i++)
          send_req(ffpa_pkg::ACT_ADD, PAGE_W'(b0 + 2 * i), 17'd1);
        send_req(ffpa_pkg::ACT_FREE, PAGE_W'(b0 + 300), LEN_W'($urandom_range(1, 20)));
        send_req(ffpa_pkg::ACT_FREE, PAGE_W'(b0 + 1), 17'd1);
        send_req(ffpa_pkg::ACT_FREE, PAGE_W'(b0 + 5), 17'd1);
        drain_table();
      end else if (ep < 85) begin
        // Unstructured requests.
        repeat ($urandom_range(10, 20)) begin
          r = $urandom_range(9);
          len = (r == 0) ? 17'd0 :
                (r == 1) ? 17'd65536 :
                (r < 5)  ? LEN_W'($urandom_range(1, 64)) :
                           LEN_W'($urandom_range(0, 65536));
          send_req(ACT_W'($urandom_range(3)), PAGE_W'($urandom()), len);
        end
      end else begin
        drain_table();
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
